>>> sv/bsm_pkg.sv
// Shared types and constants for the bounded sorted set with gap tracking.
`default_nettype none
package bsm_pkg;

    localparam int DATA_W = 32;

    typedef enum logic [1:0] {
        ST_INSERTED = 2'd0,
        ST_DUP      = 2'd1,
        ST_FULL     = 2'd2
    } status_t;

endpackage
`default_nettype wire

>>> sv/bsm_cell.sv
// One slot of the sorted chain: compare, shift-insert and neighbor gap.
`default_nettype none
module bsm_cell (
    input  wire logic                       clk,
    input  wire logic [bsm_pkg::DATA_W-1:0] value,
    input  wire logic                       insert_en,
    input  wire logic                       valid,
    input  wire logic                       gap_en,
    input  wire logic [bsm_pkg::DATA_W-1:0] left_val,
    input  wire logic                       left_lt,
    output logic [bsm_pkg::DATA_W-1:0]      val,
    output logic                            lt,
    output logic                            eq,
    output logic [bsm_pkg::DATA_W-1:0]      gap
);
    import bsm_pkg::*;

    logic [DATA_W-1:0] val_reg;
    logic [DATA_W-1:0] val_next;

    assign val = val_reg;
    assign lt  = valid && ($signed(val_reg) < $signed(value));
    assign eq  = valid && (val_reg == value);
    // gap to the left neighbor; empty slots read as all ones for the min tree
    assign gap = gap_en ? (val_reg - left_val) : {DATA_W{1'b1}};

    always_comb
    begin
        priority if (!insert_en || lt)
            val_next = val_reg;
        else if (left_lt)
            val_next = value;
        else
            val_next = left_val;
    end

    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
    end

endmodule
`default_nettype wire

>>> sv/bsm_min_tree.sv
// Registered binary minimum tree, one level resolved per clock.
`default_nettype none
module bsm_min_tree #(
    parameter int LEAVES = 64
) (
    input  wire logic                       clk,
    input  wire logic [bsm_pkg::DATA_W-1:0] leaf [LEAVES],
    output logic [bsm_pkg::DATA_W-1:0]      min_val
);
    import bsm_pkg::*;

    localparam int LEVELS = (LEAVES > 1) ? $clog2(LEAVES) : 1;
    localparam int P      = 1 << LEVELS;

    logic [DATA_W-1:0] node_reg  [1:2*P-1];
    logic [DATA_W-1:0] node_next [1:2*P-1];

    always_comb
    begin
        for (int k = 1; k < 2 * P; k++)
        begin
            if (k >= P)
            begin
                if (k - P < LEAVES)
                    node_next[k] = leaf[k-P];
                else
                    node_next[k] = {DATA_W{1'b1}};
            end
            else if (node_reg[2*k] < node_reg[2*k+1])
                node_next[k] = node_reg[2*k];
            else
                node_next[k] = node_reg[2*k+1];
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 1; k < 2 * P; k++)
            node_reg[k] <= node_next[k];
    end

    assign min_val = node_reg[1];

endmodule
`default_nettype wire

>>> sv/bounded_set_min_max_gap.sv
// Top level of the bounded sorted set with minimum gap and span reporting.
// Each accepted word inserts a signed 32-bit value into a chain of
// MAX_ENTRIES cells kept in ascending order; all cells compare against the
// value and shift right in the accept cycle. A value already held is a
// duplicate; otherwise a set holding min(capacity, MAX_ENTRIES) values is
// full. The smallest neighbor gap goes through a registered minimum tree of
// clog2(MAX_ENTRIES) levels before the result is registered, and one word is
// in flight at a time: a new word is taken once the previous result has been
// taken.
// The capacity register (reset 64) is written only while the block is idle:
// cfg_ready is low while a word is in flight, and in_ready drops while a
// capacity write is offered, so the write lands before the next word.
`default_nettype none
module bounded_set_min_max_gap #(
    parameter int MAX_ENTRIES = 64
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       cfg_valid,
    output logic                            cfg_ready,
    input  wire logic [6:0]                 capacity,
    input  wire logic                       in_valid,
    output logic                            in_ready,
    input  wire logic [bsm_pkg::DATA_W-1:0] value,
    output logic                            out_valid,
    input  wire logic                       out_ready,
    output logic [1:0]                      status,
    output logic [6:0]                      held_count,
    output logic                            spans_valid,
    output logic [bsm_pkg::DATA_W-1:0]      shortest_gap,
    output logic [bsm_pkg::DATA_W-1:0]      longest_span
);
    import bsm_pkg::*;

    localparam int CW     = $clog2(MAX_ENTRIES + 1);
    localparam int KW     = (CW > 7) ? CW : 7;
    localparam int LEVELS = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int TW     = $clog2(LEVELS + 2);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_WORK = 3'b010,
        S_OUT  = 3'b100
    } state_t;

    state_t            state_reg, state_next;
    logic [CW-1:0]     count_reg, count_next;
    logic [6:0]        cap_reg;
    logic [TW-1:0]     tick_reg, tick_next;
    logic [DATA_W-1:0] max_reg, max_next;
    status_t           status_reg, status_next;
    logic [DATA_W-1:0] gap_reg, span_reg;

    logic              in_fire, dup, full, insert_en, have_two;
    logic [KW-1:0]     limit, count_ext;
    logic [DATA_W-1:0] cell_val [MAX_ENTRIES];
    logic [DATA_W-1:0] cell_gap [MAX_ENTRIES];
    logic [MAX_ENTRIES-1:0] cell_lt, cell_eq;
    logic [DATA_W-1:0] tree_min;

    assign cfg_ready = (state_reg == S_IDLE);
    assign in_ready  = (state_reg == S_IDLE) && !cfg_valid;
    assign in_fire   = in_valid && in_ready;

    assign count_ext = KW'(count_reg);
    assign limit     = (KW'(cap_reg) > KW'(MAX_ENTRIES)) ? KW'(MAX_ENTRIES) : KW'(cap_reg);
    assign dup       = |cell_eq;
    assign full      = (count_ext >= limit);
    assign insert_en = in_fire && !dup && !full;
    assign have_two  = (count_reg >= CW'(2));

    for (genvar i = 0; i < MAX_ENTRIES; i++)
    begin : g_cell
        logic [DATA_W-1:0] left_val;
        logic              left_lt;
        if (i == 0)
        begin : g_first
            assign left_val = {DATA_W{1'b0}};
            assign left_lt  = 1'b1;
        end
        else
        begin : g_rest
            assign left_val = cell_val[i-1];
            assign left_lt  = cell_lt[i-1];
        end

        bsm_cell u_cell (
            .clk       (clk),
            .value     (value),
            .insert_en (insert_en),
            .valid     (CW'(i) < count_reg),
            .gap_en    ((i != 0) && (CW'(i) < count_reg)),
            .left_val  (left_val),
            .left_lt   (left_lt),
            .val       (cell_val[i]),
            .lt        (cell_lt[i]),
            .eq        (cell_eq[i]),
            .gap       (cell_gap[i])
        );
    end

    bsm_min_tree #(
        .LEAVES (MAX_ENTRIES)
    ) u_tree (
        .clk     (clk),
        .leaf    (cell_gap),
        .min_val (tree_min)
    );

    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        tick_next   = tick_reg;
        max_next    = max_reg;
        status_next = status_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    tick_next  = '0;
                    state_next = S_WORK;
                    priority if (dup)
                        status_next = ST_DUP;
                    else if (full)
                        status_next = ST_FULL;
                    else
                    begin
                        status_next = ST_INSERTED;
                        count_next  = count_reg + CW'(1);
                        if ((count_reg == '0) || ($signed(value) > $signed(max_reg)))
                            max_next = value;
                    end
                end
            end
            S_WORK:
            begin
                tick_next = tick_reg + TW'(1);
                // the tree leaves register the gaps after the insert, then each level in turn up to the root
                if (tick_reg == TW'(LEVELS + 1))
                    state_next = S_OUT;
            end
            S_OUT:
            begin
                if (out_ready)
                    state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            tick_reg  <= '0;
            cap_reg   <= 7'd64;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            tick_reg  <= tick_next;
            if (cfg_valid && cfg_ready)
                cap_reg <= capacity;
        end
    end

    always_ff @(posedge clk)
    begin
        max_reg    <= max_next;
        status_reg <= status_next;
        if (state_reg == S_WORK && state_next == S_OUT)
        begin
            gap_reg  <= have_two ? tree_min : {DATA_W{1'b0}};
            span_reg <= have_two ? (max_reg - cell_val[0]) : {DATA_W{1'b0}};
        end
    end

    assign out_valid    = (state_reg == S_OUT);
    assign status       = status_reg;
    assign held_count   = count_ext[6:0];
    assign spans_valid  = have_two;
    assign shortest_gap = gap_reg;
    assign longest_span = span_reg;

`ifndef SYNTH
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        KW'(count_reg) <= KW'(MAX_ENTRIES))
        else $error("held count exceeds capacity of the chain");

    a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
        insert_en |=> count_reg == $past(count_reg) + CW'(1))
        else $error("insert did not advance the count");

    a_reject_keeps: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && !insert_en) |=> count_reg == $past(count_reg))
        else $error("rejected word changed the count");

    a_gap_le_span: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && spans_valid) |-> shortest_gap <= longest_span)
        else $error("shortest gap larger than span");
`endif

endmodule
`default_nettype wire
